>>> rtl/mtt_pkg.sv
// Shared types, character codes and helpers for the markup tag tokenizer.
// No dependencies; every other file in rtl/ imports this package.
package mtt_pkg;

    localparam int LOOKAHEAD = 8;
    localparam int DT_LEN    = 8;
    localparam int WIN_DEPTH = LOOKAHEAD + 1;
    localparam int FILL_W    = $clog2(WIN_DEPTH + 1);
    localparam int POS_W     = 32;
    localparam int OUT_POS_W = 32;

    localparam logic [POS_W-1:0] POS_MAX = '1;

    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BANG  = 8'h21;

    // "!DOCTYPE"
    localparam logic [7:0] DT_WORD [DT_LEN] = '{
        8'h21, 8'h44, 8'h4F, 8'h43, 8'h54, 8'h59, 8'h50, 8'h45
    };

    typedef enum logic [1:0] {
        EV_CONTENT = 2'd0,
        EV_ATTR    = 2'd1,
        EV_END     = 2'd2
    } t_event;

    typedef enum logic [1:0] {
        KIND_TEXT    = 2'd0,
        KIND_ELEM    = 2'd1,
        KIND_COMMENT = 2'd2,
        KIND_DOCTYPE = 2'd3
    } t_kind;

    typedef struct packed {
        t_event             ev;
        t_kind              kind;
        logic [7:0]         data;
        logic               is_start;
        logic               is_end;
        logic               is_void;
        logic [POS_W-1:0]   pos;
    } t_result;

    typedef struct packed {
        logic [1:0] skip;
        logic       in_tag;
        logic       closing;
        logic       self_close;
        logic       attr;
        logic       in_comment;
        logic       in_doctype;
        logic       text_pend;
    } t_tok_state;

    typedef logic [WIN_DEPTH-1:0][7:0] t_win;

    // Saturating position advance
    function automatic logic [POS_W-1:0] pos_add(input logic [POS_W-1:0] p,
                                                 input logic [1:0] d);
        logic [POS_W:0] sum;
        sum = {1'b0, p} + {{(POS_W-1){1'b0}}, d};
        return sum[POS_W] ? POS_MAX : sum[POS_W-1:0];
    endfunction

endpackage

>>> rtl/mtt_decide.sv
// Decision logic for the oldest byte of the lookahead window.
// Depends on mtt_pkg. Purely combinational; one byte decided per call.
module mtt_decide
    import mtt_pkg::*;
(
    input  t_win               i_win,
    input  logic [FILL_W-1:0]  i_fill,
    input  t_tok_state         i_st,
    input  logic [POS_W-1:0]   i_pos,
    output logic               o_res_valid,
    output t_result            o_res,
    output t_tok_state         o_st
);

    logic [7:0] c;
    logic       dt_full;

    assign c = i_win[0];

    always_comb begin
        dt_full = (i_fill > FILL_W'(DT_LEN));
        for (int i = 0; i < DT_LEN; i++) begin
            if (i_win[i+1] != DT_WORD[i]) begin
                dt_full = 1'b0;
            end
        end
    end

    always_comb begin
        o_st        = i_st;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (i_st.skip != 2'd0) begin
            o_st.skip = i_st.skip - 2'd1;
        end else if (i_st.in_comment) begin
            o_res_valid = 1'b1;
            o_res.kind  = KIND_COMMENT;
            if (c == CH_DASH && i_fill > FILL_W'(2) && i_win[1] == CH_DASH
                    && i_win[2] == CH_GT) begin
                o_res.ev        = EV_END;
                o_res.pos       = pos_add(i_pos, 2'd2);
                o_st.skip       = 2'd2;
                o_st.in_comment = 1'b0;
            end else begin
                o_res.ev   = EV_CONTENT;
                o_res.data = c;
            end
        end else if (c == CH_LT && !i_st.in_tag && !i_st.in_doctype) begin
            // '<' closes any open text before opening its token
            if (i_st.text_pend) begin
                o_res_valid    = 1'b1;
                o_res.ev       = EV_END;
                o_res.kind     = KIND_TEXT;
                o_res.pos      = i_pos;
                o_st.text_pend = 1'b0;
            end
            if (dt_full) begin
                o_st.in_doctype = 1'b1;
            end else if (i_fill > FILL_W'(3) && i_win[1] == CH_BANG
                    && i_win[2] == CH_DASH && i_win[3] == CH_DASH) begin
                o_st.in_comment = 1'b1;
                o_st.skip       = 2'd3;
            end else begin
                o_st.in_tag = 1'b1;
                if (i_fill > FILL_W'(1) && i_win[1] == CH_SLASH) begin
                    o_st.closing = 1'b1;
                    o_st.skip    = 2'd1;
                end
            end
        end else if (i_st.in_doctype) begin
            o_res_valid = 1'b1;
            o_res.kind  = KIND_DOCTYPE;
            if (c == CH_GT) begin
                o_res.ev        = EV_END;
                o_res.pos       = i_pos;
                o_st.in_doctype = 1'b0;
            end else begin
                o_res.ev   = EV_CONTENT;
                o_res.data = c;
            end
        end else if (i_st.in_tag) begin
            if (!i_st.attr && c == CH_SPACE) begin
                o_st.attr = 1'b1;
            end else if (c == CH_SLASH && i_fill > FILL_W'(1) && i_win[1] == CH_GT) begin
                o_st.self_close = 1'b1;
                o_st.attr       = 1'b0;
                o_st.skip       = 2'd1;
            end else if (i_st.attr) begin
                o_res_valid = 1'b1;
                o_res.ev    = EV_ATTR;
                o_res.kind  = KIND_ELEM;
                o_res.data  = c;
                if (i_fill > FILL_W'(1) && i_win[1] == CH_GT) begin
                    o_st.attr = 1'b0;
                end
            end else if (c == CH_GT) begin
                o_res_valid    = 1'b1;
                o_res.ev       = EV_END;
                o_res.kind     = KIND_ELEM;
                o_res.pos      = i_pos;
                o_res.is_start = i_st.self_close || !i_st.closing;
                o_res.is_end   = i_st.self_close || i_st.closing;
                o_res.is_void  = i_st.self_close;
                o_st.in_tag     = 1'b0;
                o_st.closing    = 1'b0;
                o_st.self_close = 1'b0;
            end else begin
                o_res_valid = 1'b1;
                o_res.ev    = EV_CONTENT;
                o_res.kind  = KIND_ELEM;
                o_res.data  = c;
            end
        end else begin
            o_res_valid    = 1'b1;
            o_res.ev       = EV_CONTENT;
            o_res.kind     = KIND_TEXT;
            o_res.data     = c;
            o_st.text_pend = 1'b1;
        end
    end

endmodule

>>> rtl/mtt_emit.sv
// Result hold slot and output register; marks the final result of each input.
// Depends on mtt_pkg.
module mtt_emit
    import mtt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_work,
    input  logic                  i_new_valid,
    input  t_result               i_new,
    input  logic                  i_step_end,
    output logic                  o_can_work,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [1:0]            o_event_res,
    output logic [1:0]            o_kind,
    output logic [7:0]            o_out_byte,
    output logic                  o_is_start,
    output logic                  o_is_end,
    output logic                  o_is_void,
    output logic [OUT_POS_W-1:0]  o_position,
    output logic                  o_run_last
);

    logic    r_hv;
    logic    r_hd;      // held result is the last of its input
    t_result r_h;
    logic    r_ov;
    t_result r_o;
    logic    r_o_last;

    logic out_free;
    logic push;
    logic take_new;

    assign out_free   = !r_ov || !i_out_stall;
    assign o_can_work = out_free || !r_hv;
    assign take_new   = i_work && i_new_valid;
    assign push       = r_hv && out_free && (r_hd || take_new);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv <= 1'b0;
            r_hd <= 1'b0;
        end else if (take_new) begin
            r_hv <= 1'b1;
            r_hd <= i_step_end;
        end else if (push) begin
            r_hv <= 1'b0;
            r_hd <= 1'b0;
        end else if (i_work && i_step_end && r_hv) begin
            r_hd <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_new) begin
            r_h <= i_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_free) begin
            r_ov <= push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && push) begin
            r_o      <= r_h;
            r_o_last <= r_hd;
        end
    end

    assign o_out_valid = r_ov;
    assign o_event_res = r_o.ev;
    assign o_kind      = r_o.kind;
    assign o_out_byte  = r_o.data;
    assign o_is_start  = r_o.is_start;
    assign o_is_end    = r_o.is_end;
    assign o_is_void   = r_o.is_void;
    assign o_position  = r_o.pos[OUT_POS_W-1:0];
    assign o_run_last  = r_o_last;

endmodule

>>> rtl/markup_tag_tokenizer_unit.sv
// Markup tag tokenizer, top level: lookahead window, tokenizer state, control.
// Depends on mtt_pkg, mtt_decide and mtt_emit.
//
// Usage:
//  Input channel: one markup byte per transfer (i_in_byte, i_in_last), handshake
//  i_in_valid / o_in_stall. Output channel: one result per transfer, handshake
//  o_out_valid / i_out_stall; o_run_last marks the final result of an input byte.
//  Bytes wait in a nine-entry window until the oldest has seven bytes behind it
//  (eight when a '<' may open a doctype). Each byte normally decides one older
//  byte in the same cycle, so a byte is taken every cycle unless the unit stalls.
//  A result enters the hold slot at the transfer edge and moves on to the output
//  register once it is known to be the last of its input or the next result
//  arrives, and the register is free. Once a "<!DOCTYP" lookahead has been held
//  back, the next byte leads to two decisions, with the input held while the
//  second is made. A byte with i_in_last flushes the window: each waiting byte
//  (up to nine) is decided in turn, then any open text token is closed, with the
//  input held meanwhile; afterwards the tokenizer is back in its reset state for
//  the next document. When the receiver stalls, the output register and one hold
//  slot fill; the input then stalls too and nothing is lost or reordered.
//  Reset (synchronous, active low) empties the window, clears all token state,
//  the position counter and both output stages. The position saturates.
module markup_tag_tokenizer_unit
    import mtt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [7:0]            i_in_byte,
    input  logic                  i_in_last,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [1:0]            o_event_res,
    output logic [1:0]            o_kind,
    output logic [7:0]            o_out_byte,
    output logic                  o_is_start,
    output logic                  o_is_end,
    output logic                  o_is_void,
    output logic [OUT_POS_W-1:0]  o_position,
    output logic                  o_run_last
);

    t_win               r_win;
    logic [FILL_W-1:0]  r_fill;
    t_tok_state         r_st;
    logic [POS_W-1:0]   r_pos;
    logic               r_busy;
    logic               r_last;

    t_win               n_win;
    logic [FILL_W-1:0]  n_fill;
    t_tok_state         n_st;
    logic [POS_W-1:0]   n_pos;
    logic               n_busy;

    logic               can_work;
    logic               work;
    t_win               w1;
    logic [FILL_W-1:0]  fill1;
    logic               lastm;
    logic               tml;
    logic               m7;
    logic               rdy;
    logic               do_dec;
    logic               final_cyc;
    logic               dec_valid;
    t_result            dec_res;
    t_tok_state         dec_st;
    logic               new_valid;
    t_result            new_res;

    assign o_in_stall = r_busy || !can_work;
    assign work       = can_work && (r_busy || i_in_valid);

    // Window after taking the incoming byte
    always_comb begin
        for (int i = 0; i < WIN_DEPTH; i++) begin
            w1[i] = (!r_busy && r_fill == FILL_W'(i)) ? i_in_byte : r_win[i];
        end
        fill1 = r_busy ? r_fill : r_fill + FILL_W'(1);
        lastm = r_busy ? r_last : i_in_last;
    end

    // Readiness: hold back a '<' that may still turn out to open a doctype
    always_comb begin
        tml = (r_st.skip == 2'd0) && !r_st.in_comment && !r_st.in_tag
              && !r_st.in_doctype && (fill1 != '0) && (w1[0] == CH_LT);
        m7 = (fill1 > FILL_W'(DT_LEN - 1));
        for (int i = 0; i < DT_LEN - 1; i++) begin
            if (w1[i+1] != DT_WORD[i]) begin
                m7 = 1'b0;
            end
        end
        rdy = (fill1 >= FILL_W'(DT_LEN))
              && !((fill1 == FILL_W'(DT_LEN)) && tml && m7);
        do_dec    = (fill1 != '0) && (lastm || rdy);
        final_cyc = r_busy && (fill1 == '0);
    end

    mtt_decide u_decide (
        .i_win       (w1),
        .i_fill      (fill1),
        .i_st        (r_st),
        .i_pos       (r_pos),
        .o_res_valid (dec_valid),
        .o_res       (dec_res),
        .o_st        (dec_st)
    );

    always_comb begin
        n_win     = w1;
        n_fill    = fill1;
        n_st      = r_st;
        n_pos     = r_pos;
        n_busy    = 1'b0;
        new_valid = 1'b0;
        new_res   = dec_res;
        if (final_cyc) begin
            // flush complete: close open text at the total byte count
            new_valid      = r_st.text_pend;
            new_res        = '0;
            new_res.ev     = EV_END;
            new_res.kind   = KIND_TEXT;
            new_res.pos    = r_pos;
            n_fill         = '0;
            n_st           = '0;
            n_pos          = '0;
        end else if (do_dec) begin
            new_valid = dec_valid;
            for (int i = 0; i < WIN_DEPTH - 1; i++) begin
                n_win[i] = w1[i+1];
            end
            n_fill = fill1 - FILL_W'(1);
            n_st   = dec_st;
            n_pos  = pos_add(r_pos, 2'd1);
            n_busy = ((n_fill != '0) && (lastm || n_fill >= FILL_W'(DT_LEN)))
                     || (lastm && n_fill == '0 && dec_st.text_pend);
            if (lastm && !n_busy) begin
                n_fill = '0;
                n_st   = '0;
                n_pos  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_st   <= '0;
            r_pos  <= '0;
            r_busy <= 1'b0;
            r_last <= 1'b0;
        end else if (work) begin
            r_fill <= n_fill;
            r_st   <= n_st;
            r_pos  <= n_pos;
            r_busy <= n_busy;
            r_last <= lastm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (work) begin
            r_win <= n_win;
        end
    end

    mtt_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_work      (work),
        .i_new_valid (new_valid),
        .i_new       (new_res),
        .i_step_end  (!n_busy),
        .o_can_work  (can_work),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_event_res (o_event_res),
        .o_kind      (o_kind),
        .o_out_byte  (o_out_byte),
        .o_is_start  (o_is_start),
        .o_is_end    (o_is_end),
        .o_is_void   (o_is_void),
        .o_position  (o_position),
        .o_run_last  (o_run_last)
    );

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for markup_tag_tokenizer_unit: a byte stream goes in and
// the token events that come out are checked against a built-in tokenizer or events given by hand.
// Depends on mtt_pkg and the RTL under rtl/.
module tb_top;
    import mtt_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int RAND_ITEMS   = 170;
    localparam int MAX_PRINTS   = 40;

    typedef struct {
        t_event      ev;
        t_kind       kind;
        logic [7:0]  data;
        logic        st;
        logic        en;
        logic        vd;
        logic [31:0] pos;
        logic        last;
    } t_tok_event;

    // typed_n: -1 checks against the tokenizer, 0 or 2 gives the events of a
    // one-byte document by hand
    typedef struct {
        logic [7:0] b;
        logic       last;
        int         typed_n;
    } t_stim_row;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic [7:0]  i_in_byte   = 8'h00;
    logic        i_in_last   = 1'b0;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [1:0]  o_event_res;
    logic [1:0]  o_kind;
    logic [7:0]  o_out_byte;
    logic        o_is_start;
    logic        o_is_end;
    logic        o_is_void;
    logic [OUT_POS_W-1:0] o_position;
    logic        o_run_last;

    markup_tag_tokenizer_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_byte   (i_in_byte),
        .i_in_last   (i_in_last),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_event_res (o_event_res),
        .o_kind      (o_kind),
        .o_out_byte  (o_out_byte),
        .o_is_start  (o_is_start),
        .o_is_end    (o_is_end),
        .o_is_void   (o_is_void),
        .o_position  (o_position),
        .o_run_last  (o_run_last)
    );

    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------- tokenizer
    logic [7:0]  look_win [WIN_DEPTH];
    int          look_fill;
    int          skip_left;
    bit          tag_open, tag_closing, tag_void, attr_on;
    bit          cmt_open, dt_open, text_open;
    logic [31:0] next_pos;
    t_tok_event  step_events [$];

    t_tok_event  expected_q [$];
    logic [7:0]  doc_q [$];
    t_stim_row   dir_tab [$];
    t_tok_event  want;
    int          errors       = 0;
    int          cycle_count  = 0;
    int          items_sent   = 0;
    int          results_seen = 0;
    int          docs_sent    = 0;
    int          burst_left   = 10;
    int          tok_count [4] = '{0, 0, 0, 0};
    logic [7:0]  stall_phase  = 8'h00;

    function automatic void clear_tokenizer();
        look_fill   = 0;
        skip_left   = 0;
        tag_open    = 1'b0;
        tag_closing = 1'b0;
        tag_void    = 1'b0;
        attr_on     = 1'b0;
        cmt_open    = 1'b0;
        dt_open     = 1'b0;
        text_open   = 1'b0;
        next_pos    = '0;
    endfunction

    function automatic logic [7:0] peek(int k);
        return (k < look_fill) ? look_win[k] : 8'h00;
    endfunction

    function automatic logic [31:0] pos_plus(logic [31:0] p, int d);
        logic [32:0] s;
        s = {1'b0, p} + 33'(d);
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic void push_event(t_event ev, t_kind k, logic [7:0] d, logic st,
                                       logic en, logic vd, logic [31:0] p);
        t_tok_event e;
        e.ev   = ev;
        e.kind = k;
        e.data = d;
        e.st   = st;
        e.en   = en;
        e.vd   = vd;
        e.pos  = p;
        e.last = 1'b0;
        step_events.insert(step_events.size(), e);
    endfunction

    // the bytes after the oldest one match the first n characters of "!DOCTYPE"
    function automatic bit doctype_match(int n);
        int i;
        if (n >= look_fill) return 1'b0;
        for (i = 0; i < n; i++)
            if (peek(i + 1) != DT_WORD[i]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic bit window_ready();
        bit lt_in_text;
        lt_in_text = skip_left == 0 && !cmt_open && !tag_open && !dt_open &&
                     look_fill > 0 && look_win[0] == CH_LT;
        if (look_fill < DT_LEN) return 1'b0;
        // "<!DOCTYP" waits for one more byte to see the final letter
        if (look_fill == DT_LEN && lt_in_text && doctype_match(DT_LEN - 1)) return 1'b0;
        return 1'b1;
    endfunction

    function automatic void decide_oldest();
        logic [7:0]  c;
        logic [31:0] p;
        int          i;
        c = look_win[0];
        p = next_pos;
        if (skip_left > 0) begin
            skip_left--;
        end else if (cmt_open) begin
            if (c == CH_DASH && look_fill > 2 && peek(1) == CH_DASH && peek(2) == CH_GT) begin
                push_event(EV_END, KIND_COMMENT, 8'h00, 1'b0, 1'b0, 1'b0, pos_plus(p, 2));
                skip_left = 2;
                cmt_open  = 1'b0;
            end else begin
                push_event(EV_CONTENT, KIND_COMMENT, c, 1'b0, 1'b0, 1'b0, '0);
            end
        end else if (c == CH_LT && !tag_open && !dt_open) begin
            if (text_open) begin
                push_event(EV_END, KIND_TEXT, 8'h00, 1'b0, 1'b0, 1'b0, p);
                text_open = 1'b0;
            end
            if (doctype_match(DT_LEN)) begin
                dt_open = 1'b1;
            end else if (look_fill > 3 && peek(1) == CH_BANG && peek(2) == CH_DASH &&
                         peek(3) == CH_DASH) begin
                cmt_open  = 1'b1;
                skip_left = 3;
            end else begin
                tag_open = 1'b1;
                if (look_fill > 1 && peek(1) == CH_SLASH) begin
                    tag_closing = 1'b1;
                    skip_left   = 1;
                end
            end
        end else if (dt_open) begin
            if (c == CH_GT) begin
                push_event(EV_END, KIND_DOCTYPE, 8'h00, 1'b0, 1'b0, 1'b0, p);
                dt_open = 1'b0;
            end else begin
                push_event(EV_CONTENT, KIND_DOCTYPE, c, 1'b0, 1'b0, 1'b0, '0);
            end
        end else if (tag_open) begin
            if (!attr_on && c == CH_SPACE) begin
                attr_on = 1'b1;
            end else if (c == CH_SLASH && look_fill > 1 && peek(1) == CH_GT) begin
                // the '>' after '/' is skipped, so the tag stays open until a later '>'
                tag_void  = 1'b1;
                attr_on   = 1'b0;
                skip_left = 1;
            end else if (attr_on) begin
                push_event(EV_ATTR, KIND_ELEM, c, 1'b0, 1'b0, 1'b0, '0);
                if (look_fill > 1 && peek(1) == CH_GT) attr_on = 1'b0;
            end else if (c == CH_GT) begin
                if (tag_void)
                    push_event(EV_END, KIND_ELEM, 8'h00, 1'b1, 1'b1, 1'b1, p);
                else if (tag_closing)
                    push_event(EV_END, KIND_ELEM, 8'h00, 1'b0, 1'b1, 1'b0, p);
                else
                    push_event(EV_END, KIND_ELEM, 8'h00, 1'b1, 1'b0, 1'b0, p);
                tag_open    = 1'b0;
                tag_closing = 1'b0;
                tag_void    = 1'b0;
            end else begin
                push_event(EV_CONTENT, KIND_ELEM, c, 1'b0, 1'b0, 1'b0, '0);
            end
        end else begin
            push_event(EV_CONTENT, KIND_TEXT, c, 1'b0, 1'b0, 1'b0, '0);
            text_open = 1'b1;
        end
        for (i = 0; i < look_fill - 1; i++)
            look_win[i] = look_win[i + 1];
        look_fill--;
        next_pos = pos_plus(next_pos, 1);
    endfunction

    function automatic void tokenize_byte(logic [7:0] b, logic last);
        step_events.delete();
        if (look_fill < WIN_DEPTH) begin
            look_win[look_fill] = b;
            look_fill++;
        end
        while (look_fill > 0 && (last || window_ready()))
            decide_oldest();
        if (last) begin
            if (text_open)
                push_event(EV_END, KIND_TEXT, 8'h00, 1'b0, 1'b0, 1'b0, next_pos);
            clear_tokenizer();
        end
        if (step_events.size() > 0)
            step_events[step_events.size() - 1].last = 1'b1;
    endfunction

    // ---------------------------------------------------------------- stimulus
    function automatic void add_byte(logic [7:0] b);
        doc_q.insert(doc_q.size(), b);
    endfunction

    function automatic void push_text(string s);
        int i;
        for (i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endfunction

    function automatic void push_name();
        repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(8'h61, 8'h7A)));
    endfunction

    function automatic void push_printable(int lo, int hi);
        logic [7:0] v;
        repeat ($urandom_range(lo, hi)) begin
            v = 8'($urandom_range(8'h20, 8'h7E));
            add_byte((v == CH_GT || v == CH_LT) ? 8'h78 : v);
        end
    endfunction

    // Well-formed fragments with random content, mixed with random bytes, noise and broken openers
    function automatic void build_document();
        string kw;
        int    cut;
        doc_q.delete();
        kw = "<!DOCTYPE";
        repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(0, 11))
                0, 1, 2: repeat ($urandom_range(1, 5))
                    add_byte(8'($urandom_range(0, 255)));
                3: begin
                    add_byte(CH_LT);
                    push_name();
                    if ($urandom_range(0, 1)) begin
                        add_byte(CH_SPACE);
                        push_printable(1, 4);
                    end
                    add_byte(CH_GT);
                end
                4: begin
                    push_text("</");
                    push_name();
                    add_byte(CH_GT);
                end
                5: begin
                    add_byte(CH_LT);
                    push_name();
                    if ($urandom_range(0, 1)) begin
                        add_byte(CH_SPACE);
                        push_printable(1, 3);
                    end
                    push_text("/>");
                    if ($urandom_range(0, 1)) add_byte(CH_GT);
                end
                6: begin
                    push_text("<!--");
                    push_printable(0, 4);
                    if ($urandom_range(0, 2) == 0) add_byte(CH_DASH);
                    push_text("-->");
                end
                7: begin
                    push_text(kw);
                    if ($urandom_range(0, 1)) push_text(" html");
                    add_byte(CH_GT);
                end
                8: repeat ($urandom_range(1, 3)) begin
                    case ($urandom_range(0, 6))
                        0: add_byte(CH_LT);
                        1: add_byte(CH_GT);
                        2: add_byte(CH_DASH);
                        3: add_byte(CH_SLASH);
                        4: add_byte(CH_BANG);
                        5: add_byte(CH_SPACE);
                        default: add_byte(8'($urandom_range(0, 255)));
                    endcase
                end
                9: begin
                    // truncated or misspelt doctype opener
                    cut = $urandom_range(2, 9);
                    push_text(kw.substr(0, cut - 1));
                    if (cut == 9) doc_q[doc_q.size() - 1] = 8'h58;
                    push_printable(0, 3);
                end
                10: begin
                    push_text("<!-");
                    push_printable(0, 2);
                    add_byte(CH_GT);
                end
                default: begin
                    add_byte(CH_LT);
                    push_name();
                end
            endcase
        end
    endfunction

    task automatic send_byte(logic [7:0] b, logic last, int typed_n);
        t_tok_event e;
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        i_in_last  <= last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        tokenize_byte(b, last);
        if (typed_n < 0) begin
            foreach (step_events[k]) expected_q.insert(expected_q.size(), step_events[k]);
        end else if (typed_n == 2) begin
            e = '{EV_CONTENT, KIND_TEXT, b, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0};
            expected_q.insert(expected_q.size(), e);
            e = '{EV_END, KIND_TEXT, 8'h00, 1'b0, 1'b0, 1'b0, 32'd1, 1'b1};
            expected_q.insert(expected_q.size(), e);
        end
        items_sent++;
        if (last) docs_sent++;
        @(negedge i_clk);
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
    endtask

    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic void add_row(logic [7:0] b, logic last, int typed_n);
        t_stim_row r;
        r.b       = b;
        r.last    = last;
        r.typed_n = typed_n;
        dir_tab.insert(dir_tab.size(), r);
    endfunction

    function automatic void add_doc(string s);
        int i;
        for (i = 0; i < s.len(); i++)
            add_row(s[i], i == s.len() - 1, -1);
    endfunction

    // ---------------------------------------------------------------- receiver
    always @(negedge i_clk) begin
        stall_phase <= stall_phase + 8'd1;
        case (stall_phase[7:6])
            2'd0: i_out_stall <= 1'b0;
            2'd1: i_out_stall <= ($urandom_range(0, 3) == 0);
            2'd2: i_out_stall <= ($urandom_range(0, 3) != 0);
            default: i_out_stall <= stall_phase[2];
        endcase
    end

    task automatic report_mismatch(string what);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("error @%0d: %s", cycle_count, what);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result ev=%0d kind=%0d byte=%02h pos=%0d",
                                          o_event_res, o_kind, o_out_byte, o_position));
            end else begin
                want = expected_q.pop_front();
                if (want.ev == EV_END) tok_count[want.kind]++;
                if (o_event_res !== want.ev || o_kind !== want.kind ||
                    o_out_byte !== want.data || o_is_start !== want.st ||
                    o_is_end !== want.en || o_is_void !== want.vd ||
                    o_position !== want.pos || o_run_last !== want.last)
                    report_mismatch($sformatf(
                        "got ev%0d k%0d b%02h s%0b e%0b v%0b p%0d l%0b, want ev%0d k%0d b%02h s%0b e%0b v%0b p%0d l%0b",
                        o_event_res, o_kind, o_out_byte, o_is_start, o_is_end, o_is_void,
                        o_position, o_run_last, want.ev, want.kind, want.data, want.st,
                        want.en, want.vd, want.pos, want.last));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_q.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ---------------------------------------------------------------- sequence
    initial begin
        int  rand_sent;
        bit  drained_mid;
        rand_sent   = 0;
        drained_mid = 1'b0;
        clear_tokenizer();

        // one-byte documents: byte extremes, and a lone '<' that is dropped
        add_row(8'h00, 1'b1, 2);
        add_row(8'hFF, 1'b1, 2);
        add_row(CH_LT, 1'b1, 0);
        // text closed by a doctype, then end tag with attribute, void close, comment
        add_doc("x<!DOCTYPE>");
        add_doc("</ b/>><!---->");

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_tab[r]) send_byte(dir_tab[r].b, dir_tab[r].last, dir_tab[r].typed_n);

        while (rand_sent < RAND_ITEMS) begin
            build_document();
            foreach (doc_q[j]) send_byte(doc_q[j], j == doc_q.size() - 1, -1);
            rand_sent += doc_q.size();
            if (!drained_mid && rand_sent >= RAND_ITEMS / 2) begin
                wait_for_results();
                drained_mid = 1'b1;
            end
        end

        wait_for_results();
        repeat (30) @(posedge i_clk);

        $display("covered %0d bytes in %0d documents, %0d results checked", items_sent,
                 docs_sent, results_seen);
        $display("token ends: text %0d, element %0d, comment %0d, doctype %0d; %0d errors",
                 tok_count[KIND_TEXT], tok_count[KIND_ELEM], tok_count[KIND_COMMENT],
                 tok_count[KIND_DOCTYPE], errors);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> filelist.f
rtl/mtt_pkg.sv
rtl/mtt_decide.sv
rtl/mtt_emit.sv
rtl/markup_tag_tokenizer_unit.sv
tb/tb_top.sv
